// ===== hw/rtl/matrix_inverse_3x3_top_macros.svh =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top_macros
// assertion macros for the 3x3 inverse block
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_TOP_MACROS_SVH
`define MATRIX_INVERSE_3X3_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// shared widths and types of the 3x3 inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int MI3_FRAC_BITS_DEF = 16;
  localparam int MI3_LANES         = 9;
  localparam int MI3_ENT_W         = 32;
  localparam int MI3_ADJ_W         = 64;
  // |det| < 3 * 2^94
  localparam int MI3_DET_W         = 96;
  // low quotient bits kept, higher ones fold into a sticky flag
  localparam int MI3_Q_W           = 33;

  typedef struct packed {
    logic [MI3_DET_W-1:0] rem;
    logic [MI3_ADJ_W-1:0] num;
    logic [MI3_Q_W-1:0]   quo;
    logic                 big;
    logic                 neg;
  } mi3_lane_t;

  typedef mi3_lane_t [MI3_LANES-1:0] mi3_lanes_t;

  typedef struct packed {
    logic [MI3_LANES-1:0][MI3_ENT_W-1:0] inv;
    logic                                singular;
    logic                                saturated;
  } mi3_res_t;

endpackage

// ===== hw/rtl/matrix_inverse_3x3_top.sv =====
// path from accept to out_valid: front, divider steps, round, output register (Q16.16 by default)
// throughput: one item per cycle while in_stall is low; the divider has one quotient bit per stage
// output register plus skid entry; in_stall rises only when the skid is full
// reset (synchronous, rst_n low) empties every stage; data registers keep contents
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// pipelined 3x3 fixed-point inverse by adjugate and restoring division
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_top_macros.svh"

module matrix_inverse_3x3_top
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = MI3_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_r0c0,
  input  logic [31:0] in_r0c1,
  input  logic [31:0] in_r0c2,
  input  logic [31:0] in_r1c0,
  input  logic [31:0] in_r1c1,
  input  logic [31:0] in_r1c2,
  input  logic [31:0] in_r2c0,
  input  logic [31:0] in_r2c1,
  input  logic [31:0] in_r2c2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_inv_r0c0,
  output logic [31:0] out_inv_r0c1,
  output logic [31:0] out_inv_r0c2,
  output logic [31:0] out_inv_r1c0,
  output logic [31:0] out_inv_r1c1,
  output logic [31:0] out_inv_r1c2,
  output logic [31:0] out_inv_r2c0,
  output logic [31:0] out_inv_r2c1,
  output logic [31:0] out_inv_r2c2,
  output logic        out_singular,
  output logic        out_saturated
);

  localparam int NSTEP = MI3_ADJ_W + 2 * FRAC_BITS;

  logic                                en;
  logic [MI3_LANES-1:0][MI3_ENT_W-1:0] mat;
  mi3_lanes_t                          ch_lanes [NSTEP+1];
  logic [MI3_DET_W-1:0]                ch_dm [NSTEP+1];
  logic                                ch_sing [NSTEP+1];
  logic                                ch_vld [NSTEP+1];
  logic                                rnd_vld;
  mi3_res_t                            rnd_res;
  logic                                out_vld_r;
  mi3_res_t                            out_res_r;
  logic                                skid_vld_r;
  mi3_res_t                            skid_res_r;

  assign mat = {in_r2c2, in_r2c1, in_r2c0, in_r1c2, in_r1c1, in_r1c0,
                in_r0c2, in_r0c1, in_r0c0};

  // the whole pipe advances unless the skid entry is holding an item
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  mi3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .mat_i   (mat),
    .vld_o   (ch_vld[0]),
    .lanes_o (ch_lanes[0]),
    .dm_o    (ch_dm[0]),
    .sing_o  (ch_sing[0])
  );

  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    mi3_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_i   (ch_vld[s]),
      .lanes_i (ch_lanes[s]),
      .dm_i    (ch_dm[s]),
      .sing_i  (ch_sing[s]),
      .vld_o   (ch_vld[s+1]),
      .lanes_o (ch_lanes[s+1]),
      .dm_o    (ch_dm[s+1]),
      .sing_o  (ch_sing[s+1])
    );
  end

  mi3_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (ch_vld[NSTEP]),
    .lanes_i (ch_lanes[NSTEP]),
    .dm_i    (ch_dm[NSTEP]),
    .sing_i  (ch_sing[NSTEP]),
    .vld_o   (rnd_vld),
    .res_o   (rnd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_res_r  <= skid_res_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= rnd_vld;
        out_res_r <= rnd_res;
      end
    end else if (en && rnd_vld) begin
      // output held: park the arriving item
      skid_vld_r <= 1'b1;
      skid_res_r <= rnd_res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_inv_r0c0  = out_res_r.inv[0];
  assign out_inv_r0c1  = out_res_r.inv[1];
  assign out_inv_r0c2  = out_res_r.inv[2];
  assign out_inv_r1c0  = out_res_r.inv[3];
  assign out_inv_r1c1  = out_res_r.inv[4];
  assign out_inv_r1c2  = out_res_r.inv[5];
  assign out_inv_r2c0  = out_res_r.inv[6];
  assign out_inv_r2c1  = out_res_r.inv[7];
  assign out_inv_r2c2  = out_res_r.inv[8];
  assign out_singular  = out_res_r.singular;
  assign out_saturated = out_res_r.saturated;

  `MI3_ASSERT_IMPL(a_sing_zero, out_valid && out_singular, !out_saturated && out_inv_r0c0 == '0 && out_inv_r1c1 == '0 && out_inv_r2c2 == '0, "singular item with nonzero result")
  `MI3_ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r, "skid holds an item while output is empty")
  `MI3_ASSERT_NEXT(a_skid_fill, !skid_vld_r && !(out_valid && out_stall), !skid_vld_r, "skid filled without a held output")

endmodule

// ===== hw/rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// cofactors, determinant and operand setup for the divider lanes
// ----------------------------------------------------------------------------
module mi3_front
  import mi3_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic [MI3_LANES-1:0][MI3_ENT_W-1:0] mat_i,
  output logic                                vld_o,
  output mi3_lanes_t                          lanes_o,
  output logic [MI3_DET_W-1:0]                dm_o,
  output logic                                sing_o
);

  logic signed [MI3_ENT_W-1:0] a [MI3_LANES];
  logic signed [63:0]          p_nxt [18];
  logic signed [63:0]          p_r [18];
  logic signed [MI3_ENT_W-1:0] c1_r [3];
  logic signed [MI3_ENT_W-1:0] c2_r [3];
  logic [MI3_ADJ_W-1:0]        adj2_r [MI3_LANES];
  logic [MI3_ADJ_W-1:0]        adj3_r [MI3_LANES];
  logic [MI3_ADJ_W-1:0]        adj4_r [MI3_LANES];
  logic [MI3_ADJ_W-1:0]        adj5_r [MI3_LANES];
  logic signed [63:0]          ph_r [3];
  logic signed [64:0]          pl_r [3];
  logic [MI3_DET_W:0]          prod_r [3];
  logic [MI3_DET_W:0]          det_r;
  logic [5:0]                  vld_r;
  mi3_lanes_t                  lanes_nxt;
  logic [MI3_DET_W-1:0]        dm_nxt;
  mi3_lanes_t                  lanes_r;
  logic [MI3_DET_W-1:0]        dm_r;
  logic                        sing_r;

  always_comb begin
    for (int k = 0; k < MI3_LANES; k++) begin
      a[k] = $signed(mat_i[k]);
    end
  end

  // two products per cofactor; negated cofactors take the difference reversed
  always_comb begin
    p_nxt[0]  = a[8] * a[4];
    p_nxt[1]  = a[5] * a[7];
    p_nxt[2]  = a[8] * a[1];
    p_nxt[3]  = a[7] * a[2];
    p_nxt[4]  = a[5] * a[1];
    p_nxt[5]  = a[4] * a[2];
    p_nxt[6]  = a[8] * a[3];
    p_nxt[7]  = a[6] * a[5];
    p_nxt[8]  = a[8] * a[0];
    p_nxt[9]  = a[6] * a[2];
    p_nxt[10] = a[5] * a[0];
    p_nxt[11] = a[3] * a[2];
    p_nxt[12] = a[7] * a[3];
    p_nxt[13] = a[6] * a[4];
    p_nxt[14] = a[7] * a[0];
    p_nxt[15] = a[6] * a[1];
    p_nxt[16] = a[4] * a[0];
    p_nxt[17] = a[3] * a[1];
  end

  always_comb begin
    dm_nxt = det_r[MI3_DET_W] ? MI3_DET_W'(-det_r) : det_r[MI3_DET_W-1:0];
    for (int k = 0; k < MI3_LANES; k++) begin
      lanes_nxt[k].rem = '0;
      lanes_nxt[k].num = adj5_r[k][MI3_ADJ_W-1] ? -adj5_r[k] : adj5_r[k];
      lanes_nxt[k].quo = '0;
      lanes_nxt[k].big = 1'b0;
      lanes_nxt[k].neg = adj5_r[k][MI3_ADJ_W-1] ^ det_r[MI3_DET_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 18; k++) begin
        p_r[k] <= p_nxt[k];
      end
      c1_r[0] <= a[0];
      c1_r[1] <= a[3];
      c1_r[2] <= a[6];
      c2_r    <= c1_r;
      adj2_r[0] <= p_r[0] - p_r[1];
      adj2_r[1] <= p_r[3] - p_r[2];
      adj2_r[2] <= p_r[4] - p_r[5];
      adj2_r[3] <= p_r[7] - p_r[6];
      adj2_r[4] <= p_r[8] - p_r[9];
      adj2_r[5] <= p_r[11] - p_r[10];
      adj2_r[6] <= p_r[12] - p_r[13];
      adj2_r[7] <= p_r[15] - p_r[14];
      adj2_r[8] <= p_r[16] - p_r[17];
      for (int j = 0; j < 3; j++) begin
        ph_r[j]   <= c2_r[j] * $signed(adj2_r[j][63:32]);
        pl_r[j]   <= c2_r[j] * $signed({1'b0, adj2_r[j][31:0]});
        prod_r[j] <= {ph_r[j][63], ph_r[j], 32'b0} + {{32{pl_r[j][64]}}, pl_r[j]};
      end
      adj3_r <= adj2_r;
      adj4_r <= adj3_r;
      adj5_r <= adj4_r;
      det_r  <= prod_r[0] + prod_r[1] + prod_r[2];
      lanes_r <= lanes_nxt;
      dm_r    <= dm_nxt;
      sing_r  <= (det_r == '0);
    end
  end

  assign vld_o   = vld_r[5];
  assign lanes_o = lanes_r;
  assign dm_o    = dm_r;
  assign sing_o  = sing_r;

endmodule

// ===== hw/rtl/mi3_div_step.sv =====
// ----------------------------------------------------------------------------
// mi3_div_step
// one restoring-division quotient bit for all nine lanes
// ----------------------------------------------------------------------------
module mi3_div_step
  import mi3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  mi3_lanes_t           lanes_i,
  input  logic [MI3_DET_W-1:0] dm_i,
  input  logic                 sing_i,
  output logic                 vld_o,
  output mi3_lanes_t           lanes_o,
  output logic [MI3_DET_W-1:0] dm_o,
  output logic                 sing_o
);

  mi3_lanes_t           lanes_nxt;
  mi3_lanes_t           lanes_r;
  logic [MI3_DET_W-1:0] dm_r;
  logic                 sing_r;
  logic                 vld_r;
  logic [MI3_DET_W:0]   r2;
  logic                 ge;

  always_comb begin
    lanes_nxt = lanes_i;
    r2        = '0;
    ge        = 1'b0;
    for (int k = 0; k < MI3_LANES; k++) begin
      // dividend bits run out into zeros after the top 64
      r2 = {lanes_i[k].rem, lanes_i[k].num[MI3_ADJ_W-1]};
      ge = (r2 >= {1'b0, dm_i});
      lanes_nxt[k].rem = ge ? MI3_DET_W'(r2 - {1'b0, dm_i}) : r2[MI3_DET_W-1:0];
      lanes_nxt[k].num = {lanes_i[k].num[MI3_ADJ_W-2:0], 1'b0};
      lanes_nxt[k].quo = {lanes_i[k].quo[MI3_Q_W-2:0], ge};
      lanes_nxt[k].big = lanes_i[k].big | lanes_i[k].quo[MI3_Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
      dm_r    <= dm_i;
      sing_r  <= sing_i;
    end
  end

  assign vld_o   = vld_r;
  assign lanes_o = lanes_r;
  assign dm_o    = dm_r;
  assign sing_o  = sing_r;

endmodule

// ===== hw/rtl/mi3_round.sv =====
// ----------------------------------------------------------------------------
// mi3_round
// round to nearest, saturate, apply sign and singular override
// ----------------------------------------------------------------------------
module mi3_round
  import mi3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  mi3_lanes_t           lanes_i,
  input  logic [MI3_DET_W-1:0] dm_i,
  input  logic                 sing_i,
  output logic                 vld_o,
  output mi3_res_t             res_o
);

  localparam logic [MI3_Q_W-1:0] LIM_POS = {2'b00, {(MI3_Q_W-2){1'b1}}};
  localparam logic [MI3_Q_W-1:0] LIM_NEG = {2'b01, {(MI3_Q_W-2){1'b0}}};

  logic [MI3_Q_W-1:0]   q_r [MI3_LANES];
  logic [MI3_LANES-1:0] big_r;
  logic [MI3_LANES-1:0] neg_r;
  logic                 sing_r;
  logic [1:0]           vld_r;
  logic [MI3_Q_W:0]     qr_nxt [MI3_LANES];
  mi3_res_t             res_nxt;
  mi3_res_t             res_r;
  logic [MI3_LANES-1:0] sat;
  logic [MI3_Q_W-1:0]   lim;
  logic [MI3_Q_W-1:0]   val;

  // ties go up in magnitude: 2*rem >= |det|
  always_comb begin
    for (int k = 0; k < MI3_LANES; k++) begin
      qr_nxt[k] = {1'b0, lanes_i[k].quo}
                + (MI3_Q_W+1)'({lanes_i[k].rem, 1'b0} >= {1'b0, dm_i});
    end
  end

  always_comb begin
    res_nxt = '0;
    sat     = '0;
    lim     = '0;
    val     = '0;
    for (int k = 0; k < MI3_LANES; k++) begin
      lim    = neg_r[k] ? LIM_NEG : LIM_POS;
      sat[k] = big_r[k] || (q_r[k] > lim);
      val    = sat[k] ? lim : q_r[k];
      res_nxt.inv[k] = sing_r ? '0 :
                       (neg_r[k] ? MI3_ENT_W'(-val) : val[MI3_ENT_W-1:0]);
    end
    res_nxt.singular  = sing_r;
    res_nxt.saturated = !sing_r && (|sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MI3_LANES; k++) begin
        q_r[k]   <= qr_nxt[k][MI3_Q_W-1:0];
        big_r[k] <= lanes_i[k].big | qr_nxt[k][MI3_Q_W];
        neg_r[k] <= lanes_i[k].neg;
      end
      sing_r <= sing_i;
      res_r  <= res_nxt;
    end
  end

  assign vld_o = vld_r[1];
  assign res_o = res_r;

endmodule
